// ===== rtl/core/slcd_pkg.sv =====
// shared types and constants for the sync, length and checksum deframer
package slcd_pkg;

    // parser phase of the front part
    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_FUNC  = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

    // configuration register indexes
    localparam logic [7:0] REG_FIRST_SYNC  = 8'd0;
    localparam logic [7:0] REG_SECOND_SYNC = 8'd1;

    // reset values of the sync byte registers
    localparam logic [7:0] FIRST_SYNC_RST  = 8'h7E;
    localparam logic [7:0] SECOND_SYNC_RST = 8'h23;

    // header bytes counted in the length byte
    localparam logic [7:0] HDR_BYTES = 8'd4;

    // payload store write from the front part
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] addr;
        logic [7:0] data;
    } mem_wr_t;

    // one validated frame waiting to be drained
    typedef struct packed {
        logic [7:0] func;
        logic [7:0] plen;
        logic       bank;
    } frame_desc_t;

    // bank handed back by the back part
    typedef struct packed {
        logic en;
        logic bank;
    } bank_rel_t;

endpackage

// ===== rtl/core/slcd_front.sv =====
// front part: sync hunt, header capture, payload store writes and checksum test
module slcd_front #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  slcd_pkg::bank_rel_t  rel,
    output slcd_pkg::mem_wr_t    mem_wr,
    output logic                 push,
    output slcd_pkg::frame_desc_t push_desc
);

    localparam int IW = $clog2(BUFFER_BYTES);

    slcd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]    first_sync_reg;
    logic [7:0]    second_sync_reg;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    func_reg, func_next;
    logic [7:0]    sum_reg, sum_next;
    logic [IW-1:0] fill_reg, fill_next;
    logic          wr_bank_reg, wr_bank_next;
    logic [1:0]    busy_reg, busy_next;

    logic          accept;
    logic [7:0]    dlen;
    logic [7:0]    plen;
    logic          bad_len;

    // a data byte waits while its bank is still being drained
    assign in_stall = (phase_reg == slcd_pkg::PH_DATA) && busy_reg[wr_bank_reg];
    assign accept   = in_valid && !in_stall;

    // data length checks
    assign dlen    = (len_reg >= slcd_pkg::HDR_BYTES) ? (len_reg - slcd_pkg::HDR_BYTES) : 8'd0;
    assign bad_len = (dlen == 8'd0) || ({1'b0, dlen} > 9'(BUFFER_BYTES));
    assign plen    = dlen - 8'd1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= slcd_pkg::FIRST_SYNC_RST;
            second_sync_reg <= slcd_pkg::SECOND_SYNC_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == slcd_pkg::REG_FIRST_SYNC)
                first_sync_reg <= cfg_data;
            else if (cfg_index == slcd_pkg::REG_SECOND_SYNC)
                second_sync_reg <= cfg_data;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= slcd_pkg::PH_SYNC1;
            len_reg     <= 8'd0;
            func_reg    <= 8'd0;
            sum_reg     <= 8'd0;
            fill_reg    <= '0;
            wr_bank_reg <= 1'b0;
            busy_reg    <= 2'b00;
        end
        else
        begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            func_reg    <= func_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

    // next state, store writes and frame hand-off
    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        func_next    = func_reg;
        sum_next     = sum_reg;
        fill_next    = fill_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;
        mem_wr.en    = 1'b0;
        mem_wr.bank  = wr_bank_reg;
        mem_wr.addr  = 8'(fill_reg);
        mem_wr.data  = rx_byte;
        push         = 1'b0;
        push_desc.func = func_reg;
        push_desc.plen = plen;
        push_desc.bank = wr_bank_reg;

        if (rel.en)
            busy_next[rel.bank] = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                slcd_pkg::PH_SYNC1:
                begin
                    if (rx_byte == first_sync_reg)
                    begin
                        sum_next   = rx_byte;
                        phase_next = slcd_pkg::PH_SYNC2;
                    end
                end
                slcd_pkg::PH_SYNC2:
                begin
                    if (rx_byte == second_sync_reg)
                    begin
                        sum_next   = sum_reg + rx_byte;
                        phase_next = slcd_pkg::PH_LEN;
                    end
                    else
                        phase_next = slcd_pkg::PH_SYNC1;
                end
                slcd_pkg::PH_LEN:
                begin
                    len_next   = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = slcd_pkg::PH_FUNC;
                end
                slcd_pkg::PH_FUNC:
                begin
                    func_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    fill_next  = '0;
                    phase_next = slcd_pkg::PH_DATA;
                end
                slcd_pkg::PH_DATA:
                begin
                    if (bad_len)
                        phase_next = slcd_pkg::PH_SYNC1;
                    else if (8'(fill_reg) < plen)
                    begin
                        mem_wr.en = 1'b1;
                        sum_next  = sum_reg + rx_byte;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        // checksum byte
                        if (sum_reg == rx_byte)
                        begin
                            push                    = 1'b1;
                            busy_next[wr_bank_reg]  = 1'b1;
                            wr_bank_next            = !wr_bank_reg;
                        end
                        fill_next  = '0;
                        phase_next = slcd_pkg::PH_SYNC1;
                    end
                end
                default:
                    phase_next = slcd_pkg::PH_SYNC1;
            endcase
        end
    end

endmodule

// ===== rtl/core/slcd_queue.sv =====
// two-entry queue of validated frames between the front and back parts
module slcd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  slcd_pkg::frame_desc_t push_desc,
    input  logic                  pop,
    output logic                  not_empty,
    output slcd_pkg::frame_desc_t head
);

    slcd_pkg::frame_desc_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/slcd_back.sv =====
// back part: two-bank payload store and the drain of each frame as results
module slcd_back #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slcd_pkg::mem_wr_t     mem_wr,
    input  logic                  q_not_empty,
    input  slcd_pkg::frame_desc_t q_head,
    output logic                  q_pop,
    output slcd_pkg::bank_rel_t   rel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            func_code,
    output logic [7:0]            payload_byte,
    output logic [5:0]            byte_index,
    output logic                  has_payload,
    output logic                  last
);

    localparam int IW    = $clog2(BUFFER_BYTES);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;

    // current frame
    logic          active_reg;
    logic [7:0]    func_reg;
    logic [7:0]    plen_reg;
    logic          bank_reg;
    logic [IW-1:0] cnt_reg;

    // read stage
    logic          rd_valid_reg;
    logic [7:0]    rd_func_reg;
    logic [5:0]    rd_idx_reg;
    logic          rd_has_reg;
    logic          rd_last_reg;

    // output register
    logic          out_valid_reg;
    logic [7:0]    out_func_reg;
    logic [7:0]    out_byte_reg;
    logic [5:0]    out_idx_reg;
    logic          out_has_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          rd_free;
    logic          issue;
    logic          issue_last;
    logic          issue_has;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    assign out_free   = !out_valid_reg || !out_stall;
    assign rd_free    = !rd_valid_reg || out_free;
    assign issue      = active_reg && rd_free;
    assign issue_has  = (plen_reg != 8'd0);
    assign issue_last = !issue_has || (8'(cnt_reg) + 8'd1 == plen_reg);
    assign q_pop      = !active_reg && q_not_empty;
    assign rel.en     = issue && issue_last;
    assign rel.bank   = bank_reg;
    assign raddr      = {bank_reg, cnt_reg};
    assign waddr      = {mem_wr.bank, mem_wr.addr[IW-1:0]};

    // payload store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
            mem[waddr] <= mem_wr.data;
        if (issue && issue_has)
            rdata_reg <= mem[raddr];
    end

    // frame sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (q_pop)
            active_reg <= 1'b1;
        else if (issue && issue_last)
            active_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            func_reg <= q_head.func;
            plen_reg <= q_head.plen;
            bank_reg <= q_head.bank;
            cnt_reg  <= '0;
        end
        else if (issue)
            cnt_reg <= cnt_reg + 1'b1;
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else if (rd_free)
            rd_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_func_reg <= func_reg;
            rd_idx_reg  <= 6'(cnt_reg);
            rd_has_reg  <= issue_has;
            rd_last_reg <= issue_last;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= rd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && rd_valid_reg)
        begin
            out_func_reg <= rd_func_reg;
            out_byte_reg <= rd_has_reg ? rdata_reg : 8'd0;
            out_idx_reg  <= rd_idx_reg;
            out_has_reg  <= rd_has_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign func_code    = out_func_reg;
    assign payload_byte = out_byte_reg;
    assign byte_index   = out_idx_reg;
    assign has_payload  = out_has_reg;
    assign last         = out_last_reg;

endmodule

// ===== rtl/core/sync_length_checksum_deframer.sv =====
// top level of the sync, length and checksum deframer
//
//  channel  | signals                                            | direction
//  ---------+----------------------------------------------------+----------
//  input    | in_valid, in_stall, rx_byte                        | in
//  output   | out_valid, out_stall, func_code, payload_byte,     | out
//           | byte_index, has_payload, last                      |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data          | in
//
// every received byte is taken while in_stall is low; a good frame is emitted
// from its two-bank store one result per cycle while out_stall is low, after a
// queue pop; a frame of n results (one for a frame with no payload) drains
// behind its checksum byte.
// data bytes stall only while the bank they go to is still being drained.
// reset clears the parser, the queue and the drain; the store needs no clearing.
module sync_length_checksum_deframer #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] func_code,
    output logic [7:0] payload_byte,
    output logic [5:0] byte_index,
    output logic       has_payload,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    slcd_pkg::mem_wr_t     mem_wr;
    slcd_pkg::bank_rel_t   rel;
    slcd_pkg::frame_desc_t push_desc;
    slcd_pkg::frame_desc_t q_head;
    logic                  push;
    logic                  q_pop;
    logic                  q_not_empty;

    // configuration requests are always taken
    assign cfg_ready = 1'b1;

    // parser
    slcd_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rel       (rel),
        .mem_wr    (mem_wr),
        .push      (push),
        .push_desc (push_desc)
    );

    // frame queue
    slcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // drain
    slcd_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mem_wr       (mem_wr),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .rel          (rel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .func_code    (func_code),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .has_payload  (has_payload),
        .last         (last)
    );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the sync, length and checksum deframer
`timescale 1ns / 1ps

module testbench;

    localparam int BUFFER_BYTES = 64;
    localparam int DRAIN_CYCLES = 70;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // one expected or observed frame result
    typedef struct {
        logic [7:0] func;
        logic [7:0] data;
        logic [5:0] idx;
        logic       has;
        logic       fin;
    } frame_result_t;

    // parser copy and queue of frame results still to come
    class deframe_scoreboard;
        logic [7:0]       sync_a;
        logic [7:0]       sync_b;
        slcd_pkg::phase_t phase;
        logic [7:0]       len_byte;
        logic [7:0]       func_byte;
        logic [7:0]       sum;
        int               fill;
        logic [7:0]       store [BUFFER_BYTES];
        frame_result_t    frame_results_q [$];
        int               mismatches;
        int               checked;
        int               frames_ok;

        function new();
            sync_a     = slcd_pkg::FIRST_SYNC_RST;
            sync_b     = slcd_pkg::SECOND_SYNC_RST;
            phase      = slcd_pkg::PH_SYNC1;
            len_byte   = '0;
            func_byte  = '0;
            sum        = '0;
            fill       = 0;
            mismatches = 0;
            checked    = 0;
            frames_ok  = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [7:0] val);
            if (idx == slcd_pkg::REG_FIRST_SYNC)
                sync_a = val;
            else if (idx == slcd_pkg::REG_SECOND_SYNC)
                sync_b = val;
        endfunction

        function int outstanding();
            return frame_results_q.size();
        endfunction

        // advance the parser by one accepted byte
        function void note_byte(logic [7:0] b);
            int            dlen;
            int            plen;
            frame_result_t r;
            case (phase)
                slcd_pkg::PH_SYNC1:
                begin
                    if (b == sync_a)
                    begin
                        sum   = b;
                        phase = slcd_pkg::PH_SYNC2;
                    end
                end
                slcd_pkg::PH_SYNC2:
                begin
                    // a wrong byte here is not retried as a first sync byte
                    if (b == sync_b)
                    begin
                        sum   = sum + b;
                        phase = slcd_pkg::PH_LEN;
                    end
                    else
                        phase = slcd_pkg::PH_SYNC1;
                end
                slcd_pkg::PH_LEN:
                begin
                    len_byte = b;
                    sum      = sum + b;
                    phase    = slcd_pkg::PH_FUNC;
                end
                slcd_pkg::PH_FUNC:
                begin
                    func_byte = b;
                    sum       = sum + b;
                    fill      = 0;
                    phase     = slcd_pkg::PH_DATA;
                end
                slcd_pkg::PH_DATA:
                begin
                    dlen = (len_byte >= slcd_pkg::HDR_BYTES)
                         ? int'(len_byte) - int'(slcd_pkg::HDR_BYTES) : 0;
                    // bad length: this byte is swallowed and the frame dropped
                    if (dlen == 0 || dlen > BUFFER_BYTES)
                        phase = slcd_pkg::PH_SYNC1;
                    else
                    begin
                        plen = dlen - 1;
                        if (fill < plen)
                        begin
                            store[fill] = b;
                            sum         = sum + b;
                            fill++;
                        end
                        else
                        begin
                            // checksum byte: emit the run only on a match
                            if (sum == b)
                            begin
                                frames_ok++;
                                r.func = func_byte;
                                if (plen == 0)
                                begin
                                    r.data = '0;
                                    r.idx  = '0;
                                    r.has  = 1'b0;
                                    r.fin  = 1'b1;
                                    frame_results_q.push_back(r);
                                end
                                else
                                    for (int i = 0; i < plen; i++)
                                    begin
                                        r.data = store[i];
                                        r.idx  = i[5:0];
                                        r.has  = 1'b1;
                                        r.fin  = (i + 1 == plen);
                                        frame_results_q.push_back(r);
                                    end
                            end
                            fill  = 0;
                            phase = slcd_pkg::PH_SYNC1;
                        end
                    end
                end
                default:
                    phase = slcd_pkg::PH_SYNC1;
            endcase
        endfunction

        // compare one delivered result with the oldest one expected
        function void check_result(frame_result_t got);
            frame_result_t want;
            checked++;
            if (frame_results_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: func %h byte %h index %0d has %b last %b",
                             got.func, got.data, got.idx, got.has, got.fin);
                return;
            end
            want = frame_results_q.pop_front();
            if (got.func !== want.func || got.data !== want.data || got.idx !== want.idx ||
                got.has !== want.has || got.fin !== want.fin)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("result %0d differs", checked);
                    $display("  expected func %h byte %h index %0d has %b last %b",
                             want.func, want.data, want.idx, want.has, want.fin);
                    $display("  actual   func %h byte %h index %0d has %b last %b",
                             got.func, got.data, got.idx, got.has, got.fin);
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] func_code;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       has_payload;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    deframe_scoreboard sb = new();
    logic [7:0]        payload_buf [BUFFER_BYTES];
    bit                calm_tail = 1'b0;
    int                bytes_sent = 0;
    int                settings_used = 1;
    int                stall_left = 0;
    int                cycles = 0;

    sync_length_checksum_deframer #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .func_code   (func_code),
        .payload_byte(payload_byte),
        .byte_index  (byte_index),
        .has_payload (has_payload),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sync_length_checksum_deframer: mismatch");
        $finish;
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (calm_tail)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(1, 17);
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        frame_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.func = func_code;
            got.data = payload_byte;
            got.idx  = byte_index;
            got.has  = has_payload;
            got.fin  = last;
            sb.check_result(got);
        end
    end

    // one byte request, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // hold off input until every result has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write both sync byte registers back to back
    task automatic load_sync_regs(input logic [7:0] first_val, input logic [7:0] second_val);
        cfg_valid <= 1'b1;
        cfg_index <= slcd_pkg::REG_FIRST_SYNC;
        cfg_data  <= first_val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sb.set_reg(slcd_pkg::REG_FIRST_SYNC, first_val);
        cfg_index <= slcd_pkg::REG_SECOND_SYNC;
        cfg_data  <= second_val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sb.set_reg(slcd_pkg::REG_SECOND_SYNC, second_val);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // whole frame from payload_buf, checksum offset by chk_err
    task automatic send_frame(input logic [7:0] len, input logic [7:0] func,
                              input int nbytes, input logic [7:0] chk_err);
        logic [7:0] chk;
        chk = sb.sync_a + sb.sync_b + len + func;
        send_byte(sb.sync_a);
        send_byte(sb.sync_b);
        send_byte(len);
        send_byte(func);
        for (int i = 0; i < nbytes; i++)
        begin
            send_byte(payload_buf[i]);
            chk = chk + payload_buf[i];
        end
        send_byte(chk + chk_err);
    endtask

    // mostly good frames, some corrupted ones and line noise
    task automatic send_random_frame();
        int         kind;
        int         plen;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
        for (int i = 0; i < plen; i++)
            payload_buf[i] = 8'($urandom_range(0, 255));
        if (kind < 70)
            send_frame(8'(plen + 5), 8'($urandom_range(0, 255)), plen, 8'h00);
        else if (kind < 78)
            send_frame(8'(plen + 5), 8'($urandom_range(0, 255)), plen,
                       8'($urandom_range(1, 255)));
        else if (kind < 85)
        begin
            // length with no data or more than the store holds
            b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 4))
                                            : 8'($urandom_range(69, 255));
            send_frame(b, 8'($urandom_range(0, 255)), 0, 8'($urandom_range(0, 255)));
        end
        else if (kind < 93)
            repeat ($urandom_range(1, 4))
            begin
                b = 8'($urandom_range(0, 255));
                if (b == sb.sync_a)
                    b = b ^ 8'h01;
                send_byte(b);
            end
        else
        begin
            send_byte(sb.sync_a);
            send_byte(sb.sync_b ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_random_bytes(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
            send_random_frame();
    endtask

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = slcd_pkg::REG_FIRST_SYNC;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty frame with the lowest function code
        send_frame(8'd5, 8'h00, 0, 8'h00);
        // bad second sync, the repeated first sync byte does not restart the hunt
        send_byte(slcd_pkg::FIRST_SYNC_RST);
        send_byte(slcd_pkg::FIRST_SYNC_RST);
        send_byte(slcd_pkg::SECOND_SYNC_RST);
        // length one past the store
        send_frame(8'd69, 8'h22, 0, 8'h00);
        // sync bytes and byte extremes inside the payload
        payload_buf[0] = 8'h00;
        payload_buf[1] = slcd_pkg::FIRST_SYNC_RST;
        payload_buf[2] = 8'hFF;
        send_frame(8'd8, 8'hFF, 3, 8'h00);
        // checksum off by one
        send_frame(8'd5, 8'h81, 0, 8'h01);
        // registers changed between the sync bytes and the rest of the frame
        send_byte(slcd_pkg::FIRST_SYNC_RST);
        send_byte(slcd_pkg::SECOND_SYNC_RST);
        wait_idle();
        load_sync_regs(8'h55, slcd_pkg::SECOND_SYNC_RST);
        send_byte(8'd5);
        send_byte(8'h3C);
        send_byte(slcd_pkg::FIRST_SYNC_RST + slcd_pkg::SECOND_SYNC_RST + 8'd5 + 8'h3C);
        wait_idle();

        // random traffic under several sync settings
        load_sync_regs(8'h00, 8'hFF);
        send_random_bytes(5);
        wait_idle();
        load_sync_regs(8'hFF, 8'h00);
        send_random_bytes(5);
        wait_idle();
        cfg_data <= 8'($urandom_range(0, 255));
        @(posedge clk);
        load_sync_regs(cfg_data, cfg_data);
        send_random_bytes(5);
        wait_idle();

        // final stretch without idling, including the longest frame
        load_sync_regs(slcd_pkg::FIRST_SYNC_RST, slcd_pkg::SECOND_SYNC_RST);
        calm_tail = 1'b1;
        for (int i = 0; i < 63; i++)
            payload_buf[i] = 8'($urandom_range(0, 255));
        send_frame(8'd68, 8'($urandom_range(0, 255)), 63, 8'h00);
        send_random_bytes(5);
        wait_idle();

        $display("sent %0d bytes under %0d sync settings, %0d frames accepted",
                 bytes_sent, settings_used, sb.frames_ok);
        $display("checked %0d results, %0d wrong", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("sync_length_checksum_deframer: match");
        else
            $display("sync_length_checksum_deframer: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/slcd_pkg.sv
rtl/core/slcd_front.sv
rtl/core/slcd_queue.sv
rtl/core/slcd_back.sv
rtl/core/sync_length_checksum_deframer.sv
tb/testbench.sv
